### hdl/ray_box_slab_intersect_core_assert.svh
// Assertion macros used by the port checker of the slab test core.
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define RBSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every rising clock edge, reset included.
`define RBSI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// Slab test package
// Shared types and constants for the ray versus box slab test core.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   // Default number of fraction bits of the signed fixed-point format.
   localparam int FRAC_BITS_DEF = 16;

   // Width of every coordinate and distance.
   localparam int VAL_W = 32;

   // Quotient bits produced by the pipelined divider, one per stage.
   localparam int DIV_STEPS = 32;

   // Divider stages: operand stage, range check stage, steps, saturation stage.
   localparam int DIV_LAT = DIV_STEPS + 3;

   // Axis lane adds one ordering stage after its dividers.
   localparam int LANE_LAT = DIV_LAT + 1;

   // Merge stage depth.
   localparam int MERGE_LAT = 2;

   // Whole pipeline depth from accepted transaction to result register.
   localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

   localparam int AXES = 3;

   typedef logic signed [VAL_W-1:0] val_type;

   localparam val_type TMAX = 32'sh7FFF_FFFF;
   localparam val_type TMIN = -32'sh7FFF_FFFF;

endpackage

### hdl/rbsi_div_lane.sv
// ----------------------------------------------------------------------------
// Plane distance divider
// Pipelined (bound - origin) * 2^F / direction, truncated and saturated.
// ----------------------------------------------------------------------------
module rbsi_div_lane #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  rbsi_pkg::val_type bound,
   input  rbsi_pkg::val_type org,
   input  rbsi_pkg::val_type dir,
   output rbsi_pkg::val_type distance
);
   import rbsi_pkg::*;

   localparam int NW = VAL_W + 1 + FRAC_BITS;
   localparam int HW = NW - DIV_STEPS;

   logic [VAL_W:0]   diff;
   logic [VAL_W:0]   nmag_in;
   logic [VAL_W-1:0] dmag_in;
   logic [VAL_W:0]   nmag_ff;
   logic [VAL_W-1:0] dmag_ff;
   logic             neg1_ff;

   logic [NW-1:0]    ntot;
   logic [HW-1:0]    hi_part;
   logic [VAL_W-1:0] hi_ext;
   logic             ovf_in;

   logic [VAL_W-1:0] rem_ff [0:DIV_STEPS];
   logic [VAL_W-1:0] low_ff [0:DIV_STEPS];
   logic [VAL_W-1:0] quo_ff [0:DIV_STEPS];
   logic [VAL_W-1:0] dv_ff  [0:DIV_STEPS];
   logic             neg_ff [0:DIV_STEPS];
   logic             ovf_ff [0:DIV_STEPS];

   logic [VAL_W-1:0] mag;
   val_type          dist_in;
   val_type          dist_ff;

   // Operand stage: exact 33-bit difference and both magnitudes.
   assign diff    = {bound[VAL_W-1], bound} - {org[VAL_W-1], org};
   assign nmag_in = diff[VAL_W] ? (~diff + 1'b1) : diff;
   assign dmag_in = dir[VAL_W-1] ? (~dir + 1'b1) : dir;

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= nmag_in;
         dmag_ff <= dmag_in;
         neg1_ff <= diff[VAL_W] ^ dir[VAL_W-1];
      end
   end

   // Range check: the quotient fits in 32 bits only when the part above
   // the low 32 dividend bits is below the divisor.
   assign ntot    = {nmag_ff, {FRAC_BITS{1'b0}}};
   assign hi_part = ntot[NW-1:DIV_STEPS];
   assign hi_ext  = {{(VAL_W-HW){1'b0}}, hi_part};
   assign ovf_in  = (hi_ext >= dmag_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= ovf_in ? '0 : hi_ext;
         low_ff[0] <= ntot[DIV_STEPS-1:0];
         quo_ff[0] <= '0;
         dv_ff[0]  <= dmag_ff;
         neg_ff[0] <= neg1_ff;
         ovf_ff[0] <= ovf_in;
      end
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [VAL_W:0] trial;
      logic [VAL_W:0] sub;
      logic           ge;

      assign trial = {rem_ff[k-1], low_ff[k-1][VAL_W-1]};
      assign sub   = trial - {1'b0, dv_ff[k-1]};
      assign ge    = (trial >= {1'b0, dv_ff[k-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? sub[VAL_W-1:0] : trial[VAL_W-1:0];
            low_ff[k] <= {low_ff[k-1][VAL_W-2:0], 1'b0};
            quo_ff[k] <= {quo_ff[k-1][VAL_W-2:0], ge};
            dv_ff[k]  <= dv_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // Saturate the magnitude, then restore the sign.
   assign mag     = (ovf_ff[DIV_STEPS] || quo_ff[DIV_STEPS][VAL_W-1])
                    ? TMAX : quo_ff[DIV_STEPS];
   assign dist_in = neg_ff[DIV_STEPS] ? -val_type'(mag) : val_type'(mag);

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end

   assign distance = dist_ff;

endmodule

### hdl/rbsi_axis_lane.sv
// ----------------------------------------------------------------------------
// Axis lane
// Both plane distances of one axis, ordered into entry and exit bounds.
// ----------------------------------------------------------------------------
module rbsi_axis_lane #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              en,
   input  rbsi_pkg::val_type lo,
   input  rbsi_pkg::val_type hi,
   input  rbsi_pkg::val_type org,
   input  rbsi_pkg::val_type dir,
   output rbsi_pkg::val_type near,
   output rbsi_pkg::val_type far
);
   import rbsi_pkg::*;

   val_type d_lo;
   val_type d_hi;
   logic    zero_ff [0:DIV_LAT-1];
   val_type near_ff;
   val_type far_ff;

   rbsi_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clock(clock), .en(en), .bound(lo), .org(org), .dir(dir), .distance(d_lo)
   );

   rbsi_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clock(clock), .en(en), .bound(hi), .org(org), .dir(dir), .distance(d_hi)
   );

   // A zero direction travels beside the dividers and turns the lane neutral.
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (dir == '0);
         for (int i = 1; i < DIV_LAT; i++) begin
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[DIV_LAT-1]) begin
            near_ff <= TMIN;
            far_ff  <= TMAX;
         end else if (d_lo < d_hi) begin
            near_ff <= d_lo;
            far_ff  <= d_hi;
         end else begin
            near_ff <= d_hi;
            far_ff  <= d_lo;
         end
      end
   end

   assign near = near_ff;
   assign far  = far_ff;

endmodule

### hdl/rbsi_merge.sv
// ----------------------------------------------------------------------------
// Lane merge
// Narrows the entry and exit bounds of all axes and applies the box check.
// ----------------------------------------------------------------------------
module rbsi_merge (
   input  logic              clock,
   input  logic              en,
   input  rbsi_pkg::val_type near [rbsi_pkg::AXES],
   input  rbsi_pkg::val_type far  [rbsi_pkg::AXES],
   input  logic              inverted,
   output rbsi_pkg::val_type t_near,
   output rbsi_pkg::val_type t_far,
   output logic              box_inverted
);
   import rbsi_pkg::*;

   val_type n01_ff;
   val_type f01_ff;
   val_type n2_ff;
   val_type f2_ff;
   logic    inv1_ff;
   val_type t_near_ff;
   val_type t_far_ff;
   logic    inv2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n01_ff  <= (near[0] > near[1]) ? near[0] : near[1];
         f01_ff  <= (far[0] < far[1]) ? far[0] : far[1];
         n2_ff   <= near[2];
         f2_ff   <= far[2];
         inv1_ff <= inverted;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv2_ff <= inv1_ff;
         if (inv1_ff) begin
            t_near_ff <= '0;
            t_far_ff  <= '0;
         end else begin
            t_near_ff <= (n2_ff > n01_ff) ? n2_ff : n01_ff;
            t_far_ff  <= (f2_ff < f01_ff) ? f2_ff : f01_ff;
         end
      end
   end

   assign t_near       = t_near_ff;
   assign t_far        = t_far_ff;
   assign box_inverted = inv2_ff;

endmodule

### hdl/ray_box_slab_intersect_core.sv
// ----------------------------------------------------------------------------
// Ray versus axis-aligned box slab test core
// Streams one box and one ray per transaction and returns entry and exit
// distances in signed fixed point.
// ----------------------------------------------------------------------------
// The core accepts one transaction per clock cycle while the result side does
// not stall and returns one result transaction for each, in order, once it
// has passed the PIPE_LAT stages (35 divider stages including the operand
// register, one ordering stage and two merge stages). Three axis lanes run
// side by side, each with two fully pipelined restoring dividers that retire
// one quotient bit per stage; the 32-step divider sets the depth, and
// throughput stays at one transaction per cycle while nothing stalls. The
// whole pipeline advances whenever the result register is empty or being
// taken, so req_tready only drops while a finished result waits for
// rsp_tready. A box with any min above its max returns zero distances and
// box_inverted set; an axis with zero direction constrains nothing, and a
// ray with no constraint returns the format extremes.
module ray_box_slab_intersect_core #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
   // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
   input  logic [383:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // t_near, t_far
   output logic [63:0]  rsp_tdata,
   // box_inverted
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);
   import rbsi_pkg::*;

   logic    en;
   logic    vld_ff [0:PIPE_LAT-1];
   logic    inv_ff [0:LANE_LAT-1];
   logic    inv_in;
   val_type lo   [AXES];
   val_type hi   [AXES];
   val_type org  [AXES];
   val_type dir  [AXES];
   val_type near [AXES];
   val_type far  [AXES];
   val_type t_near;
   val_type t_far;
   logic    box_inverted;

   // Every stage moves together; a held result stalls the pipe.
   assign en         = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = en;

   for (genvar a = 0; a < AXES; a++) begin : g_unpack
      assign lo[a]  = val_type'(req_tdata[VAL_W*a +: VAL_W]);
      assign hi[a]  = val_type'(req_tdata[VAL_W*(AXES+a) +: VAL_W]);
      assign org[a] = val_type'(req_tdata[VAL_W*(2*AXES+a) +: VAL_W]);
      assign dir[a] = val_type'(req_tdata[VAL_W*(3*AXES+a) +: VAL_W]);
   end

   assign inv_in = (lo[0] > hi[0]) || (lo[1] > hi[1]) || (lo[2] > hi[2]);

   // Transaction valid marks ride alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // The inverted-box flag waits for the lanes and then reaches the merge.
   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff[0] <= inv_in;
         for (int i = 1; i < LANE_LAT; i++) begin
            inv_ff[i] <= inv_ff[i-1];
         end
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      rbsi_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock),
         .en   (en),
         .lo   (lo[a]),
         .hi   (hi[a]),
         .org  (org[a]),
         .dir  (dir[a]),
         .near (near[a]),
         .far  (far[a])
      );
   end

   rbsi_merge u_merge (
      .clock       (clock),
      .en          (en),
      .near        (near),
      .far         (far),
      .inverted    (inv_ff[LANE_LAT-1]),
      .t_near      (t_near),
      .t_far       (t_far),
      .box_inverted(box_inverted)
   );

   assign rsp_tdata  = {t_far, t_near};
   assign rsp_tuser  = box_inverted;
   assign rsp_tvalid = vld_ff[PIPE_LAT-1];

endmodule

### hdl/rbsi_checker.sv
// ----------------------------------------------------------------------------
// Slab test port checker
// Port-level checks of the slab test core, bound to its top level.
// ----------------------------------------------------------------------------
`include "ray_box_slab_intersect_core_assert.svh"

module rbsi_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic [63:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // A stalled result stays offered with its distances unchanged.
   `RBSI_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // An inverted box always reports zero distances.
   `RBSI_ASSERT(a_inv_zero, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0, "inverted box with nonzero distances")

   // Saturation never yields the most negative code.
   `RBSI_ASSERT(a_no_min_code, clock, reset, rsp_tvalid |-> rsp_tdata[31:0] != 32'h8000_0000 && rsp_tdata[63:32] != 32'h8000_0000, "distance holds the most negative code")

   // With no result pending the core takes input, and reset leaves nothing pending.
   `RBSI_ASSERT_ALWAYS(a_ready_free, clock, !rsp_tvalid |-> req_tready, "input stalled with no result pending")
   `RBSI_ASSERT(a_reset_empty, clock, reset, $past(reset) |-> !rsp_tvalid, "result valid right after reset")

endmodule

bind ray_box_slab_intersect_core rbsi_checker u_rbsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready)
);
